FILE: src/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock while out of reset.
`define CHK_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Implication whose consequent is checked on the next clock.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

FILE: src/twt_pkg.sv
// Shared types and constants of the timing wheel timer table.
package twt_pkg;

  localparam logic [1:0] KIND_REG   = 2'd0;
  localparam logic [1:0] KIND_UNREG = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;
  localparam logic [1:0] KIND_BAD   = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_INVALID   = 3'd1;
  localparam logic [2:0] ST_DUPLICATE = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;
  localparam logic [2:0] ST_EXPIRED   = 3'd5;
  localparam logic [2:0] ST_NONE      = 3'd6;

  localparam logic [12:0] SLOTS_RESET = 13'd1000;

  // Command beat handed from the front part to the back part.
  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] timer_id;
    logic        loop_mode;
    logic [31:0] duration;
  } cmd_t;

  // Result beat.
  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] result_id;
    logic        last;
  } res_t;

endpackage

FILE: src/twt_front.sv
// Front part: accept input beats, drop unknown kinds, queue commands.
module twt_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  twt_pkg::cmd_t      in_cmd,
  output logic               cq_valid,
  input  logic               cq_take,
  output twt_pkg::cmd_t      cq_cmd
);

  twt_pkg::cmd_t q_r [2];
  logic [1:0]    cnt_r;
  logic          rd_r;
  logic          wr_r;
  logic          acc;
  logic          keep;

  assign in_full  = (cnt_r == 2'd2);
  assign acc      = in_push && !in_full;
  // Kind three is dropped at the door.
  assign keep     = acc && (in_cmd.kind != twt_pkg::KIND_BAD);
  assign cq_valid = (cnt_r != 2'd0);
  assign cq_cmd   = q_r[rd_r];

  // Hold queue pointers and count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
    end else begin
      if (keep) wr_r <= !wr_r;
      if (cq_take) rd_r <= !rd_r;
      cnt_r <= cnt_r + {1'b0, keep} - {1'b0, cq_take};
    end
  end

  // Store command payload.
  always_ff @(posedge clk) begin
    if (keep) q_r[wr_r] <= in_cmd;
  end

endmodule

FILE: src/twt_back.sv
// Back part: divide, table scan and result generation.
module twt_back #(
  parameter int MAX_TIMERS = 16,
  parameter int SLOT_BITS  = 12
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [12:0]         slots_cfg,
  input  logic                cq_valid,
  output logic                cq_take,
  input  twt_pkg::cmd_t       cq_cmd,
  output logic                rq_push,
  input  logic                rq_full,
  output twt_pkg::res_t       rq_res
);

  localparam int IW = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
  localparam int SW = SLOT_BITS + 1;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_PMOD = 7'b0000010,
    S_DIV  = 7'b0000100,
    S_FIND = 7'b0001000,
    S_SCAN = 7'b0010000,
    S_OUT  = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t            st_r, st_nxt;
  twt_pkg::cmd_t     cmd_r;
  logic [SW-1:0]     slots_r;
  logic [SLOT_BITS-1:0] ptr_r;
  logic [SLOT_BITS-1:0] psh_r;
  logic [SLOT_BITS-1:0] pmod_r;
  logic [31:0]       quo_r;
  logic [SW-1:0]     rem_r;
  logic [5:0]        dcnt_r;
  logic [IW:0]       ix_r;
  logic              hit_r;
  logic [IW-1:0]     hix_r;
  logic              fre_r;
  logic [IW-1:0]     fix_r;
  logic              pend_r;
  logic [31:0]       pid_r;

  logic [MAX_TIMERS-1:0] vld_r;
  logic [31:0]           eid_r  [MAX_TIMERS];
  logic                  eper_r [MAX_TIMERS];
  logic [SLOT_BITS-1:0]  eslot_r[MAX_TIMERS];
  logic [31:0]           erel_r [MAX_TIMERS];
  logic [31:0]           eleft_r[MAX_TIMERS];

  logic [IW-1:0]     ix;
  logic              ix_end;
  logic [SW-1:0]     eff;
  logic              dbit;
  logic [SW:0]       trial;
  logic              tge;
  logic [SW-1:0]     rem_step;
  logic [SW:0]       psum;
  logic [SLOT_BITS-1:0] pos;
  logic [SW-1:0]     pinc;
  logic              scan_hit;

  assign ix     = ix_r[IW-1:0];
  assign ix_end = (ix_r == (IW+1)'(MAX_TIMERS));

  // Clamp the slot count to 1 .. 2^SLOT_BITS.
  always_comb begin
    if (slots_cfg == 13'd0) eff = SW'(1);
    else if ({19'd0, slots_cfg} > (32'd1 << SLOT_BITS)) eff = SW'(1) << SLOT_BITS;
    else eff = SW'(slots_cfg);
  end

  // Restoring remainder step: pointer bits first, then duration bits.
  assign dbit     = (st_r == S_PMOD) ? psh_r[SLOT_BITS-1] : cmd_r.duration[~dcnt_r[4:0]];
  assign trial    = {rem_r, dbit};
  assign tge      = (trial >= {1'b0, slots_r});
  assign rem_step = tge ? SW'(trial - {1'b0, slots_r}) : SW'(trial);

  // Both terms are below the slot count, so one subtract wraps the sum.
  assign psum  = {1'b0, rem_r} + {2'b0, pmod_r};
  assign pos   = (psum >= {1'b0, slots_r}) ? SLOT_BITS'(psum - {1'b0, slots_r})
                                           : SLOT_BITS'(psum);
  assign pinc  = {1'b0, ptr_r} + SW'(1);

  // Entry under the scan expires on this tick.
  assign scan_hit = (st_r == S_SCAN) && !ix_end && vld_r[ix] && (eslot_r[ix] == ptr_r) &&
                    (eleft_r[ix] == 32'd0);

  assign cq_take = (st_r == S_IDLE) && cq_valid;

  // Sequence one command.
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: begin
        if (cq_valid) begin
          if (cq_cmd.kind == twt_pkg::KIND_REG) st_nxt = S_PMOD;
          else if (cq_cmd.kind == twt_pkg::KIND_TICK) st_nxt = S_SCAN;
          else st_nxt = S_FIND;
        end
      end
      S_PMOD: if (dcnt_r == 6'(SLOT_BITS - 1)) st_nxt = S_DIV;
      S_DIV:  if (dcnt_r == 6'd31) st_nxt = S_FIND;
      S_FIND: if (ix_r == (IW+1)'(MAX_TIMERS - 1)) st_nxt = S_OUT;
      S_SCAN: if (ix_end) st_nxt = S_DONE;
      S_OUT:  if (!rq_full) st_nxt = S_IDLE;
      S_DONE: if (!rq_full) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= S_IDLE;
    else st_r <= st_nxt;
  end

  // Datapath and table update.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      ptr_r  <= '0;
      pend_r <= 1'b0;
    end else begin
      case (st_r)
        S_IDLE: begin
          if (cq_valid) begin
            cmd_r   <= cq_cmd;
            slots_r <= eff;
            psh_r   <= ptr_r;
            dcnt_r  <= '0;
            rem_r   <= '0;
            ix_r    <= '0;
            hit_r   <= 1'b0;
            fre_r   <= 1'b0;
            pend_r  <= 1'b0;
            // Advance the pointer before the scan.
            if (cq_cmd.kind == twt_pkg::KIND_TICK) begin
              ptr_r <= (pinc >= eff) ? '0 : SLOT_BITS'(pinc);
            end
          end
        end
        S_PMOD: begin
          psh_r <= psh_r << 1;
          if (dcnt_r == 6'(SLOT_BITS - 1)) begin
            dcnt_r <= '0;
            rem_r  <= '0;
            pmod_r <= SLOT_BITS'(rem_step);
          end else begin
            dcnt_r <= dcnt_r + 6'd1;
            rem_r  <= rem_step;
          end
        end
        S_DIV: begin
          dcnt_r <= dcnt_r + 6'd1;
          rem_r  <= rem_step;
          quo_r  <= {quo_r[30:0], tge};
        end
        S_FIND: begin
          ix_r <= ix_r + 1'b1;
          if (vld_r[ix] && eid_r[ix] == cmd_r.timer_id && !hit_r) begin
            hit_r <= 1'b1;
            hix_r <= ix;
          end
          if (!vld_r[ix] && !fre_r) begin
            fre_r <= 1'b1;
            fix_r <= ix;
          end
        end
        S_SCAN: begin
          if (scan_hit) begin
            // Stall while the held expiry cannot leave.
            if (!(pend_r && rq_full)) begin
              ix_r   <= ix_r + 1'b1;
              pend_r <= 1'b1;
              pid_r  <= eid_r[ix];
              if (eper_r[ix]) eleft_r[ix] <= erel_r[ix];
              else vld_r[ix] <= 1'b0;
            end
          end else if (!ix_end) begin
            ix_r <= ix_r + 1'b1;
            if (vld_r[ix] && eslot_r[ix] == ptr_r) eleft_r[ix] <= eleft_r[ix] - 32'd1;
          end
        end
        S_OUT: begin
          if (!rq_full && cmd_r.timer_id != 32'd0) begin
            if (cmd_r.kind == twt_pkg::KIND_REG && !hit_r && fre_r) begin
              vld_r[fix_r]   <= 1'b1;
              eid_r[fix_r]   <= cmd_r.timer_id;
              eper_r[fix_r]  <= cmd_r.loop_mode;
              eslot_r[fix_r] <= pos;
              erel_r[fix_r]  <= quo_r;
              eleft_r[fix_r] <= quo_r;
            end
            if (cmd_r.kind == twt_pkg::KIND_UNREG && hit_r) vld_r[hix_r] <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Form result beats. An expiry is held until the next one is found or the
  // scan ends, so that last is known when it leaves.
  always_comb begin
    rq_push = 1'b0;
    rq_res  = '0;
    case (st_r)
      S_OUT: begin
        rq_push          = 1'b1;
        rq_res.result_id = cmd_r.timer_id;
        rq_res.last      = 1'b1;
        if (cmd_r.timer_id == 32'd0) rq_res.status = twt_pkg::ST_INVALID;
        else if (cmd_r.kind == twt_pkg::KIND_REG) begin
          if (hit_r) rq_res.status = twt_pkg::ST_DUPLICATE;
          else if (!fre_r) rq_res.status = twt_pkg::ST_FULL;
          else rq_res.status = twt_pkg::ST_OK;
        end else begin
          rq_res.status = hit_r ? twt_pkg::ST_OK : twt_pkg::ST_NOT_FOUND;
        end
      end
      S_SCAN: begin
        // Release the held expiry once another is found.
        rq_push          = scan_hit && pend_r;
        rq_res.status    = twt_pkg::ST_EXPIRED;
        rq_res.result_id = pid_r;
        rq_res.last      = 1'b0;
      end
      S_DONE: begin
        rq_push = 1'b1;
        rq_res.last = 1'b1;
        if (pend_r) begin
          rq_res.status    = twt_pkg::ST_EXPIRED;
          rq_res.result_id = pid_r;
        end else begin
          rq_res.status = twt_pkg::ST_NONE;
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: src/twt_outq.sv
// Result queue between the back part and the result ports.
module twt_outq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          rq_push,
  output logic          rq_full,
  input  twt_pkg::res_t rq_res,
  output logic          out_empty,
  input  logic          out_pop,
  output twt_pkg::res_t out_res
);

  twt_pkg::res_t q_r [2];
  logic [1:0]    cnt_r;
  logic          rd_r;
  logic          wr_r;
  logic          wr;
  logic          rd;

  assign rq_full   = (cnt_r == 2'd2);
  assign out_empty = (cnt_r == 2'd0);
  assign wr        = rq_push && !rq_full;
  assign rd        = out_pop && !out_empty;
  assign out_res   = q_r[rd_r];

  // Advance pointers and count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
    end else begin
      if (wr) wr_r <= !wr_r;
      if (rd) rd_r <= !rd_r;
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
  end

  always_ff @(posedge clk) begin
    if (wr) q_r[wr_r] <= rq_res;
  end

endmodule

FILE: src/timing_wheel_timer_table.sv
// Hashed timing wheel timer table. Input beats queue in a two-entry command
// queue and reach the back part when it is idle; the back part runs one
// command at a time. Register takes an accept step, a SLOT_BITS-step
// reduction of the pointer by the slot count, a 32-step restoring divide of
// the duration, a MAX_TIMERS-entry id/free scan and a result step;
// unregister takes the accept step, the id scan and the result step; tick
// advances the pointer, scans the table and stalls on each expiry found
// while the result queue is full. Results leave through a two-entry queue.
// Table contents need no clearing after reset.
module timing_wheel_timer_table #(
  parameter int MAX_TIMERS = 16,
  parameter int SLOT_BITS  = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [12:0] cfg_wheel_slots,
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_kind,
  input  logic [31:0] in_timer_id,
  input  logic        in_loop_mode,
  input  logic [31:0] in_duration,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [2:0]  out_status,
  output logic [31:0] out_result_id,
  output logic        out_last
);

  logic [12:0]   slots_r;
  twt_pkg::cmd_t in_cmd, cq_cmd;
  twt_pkg::res_t rq_res, out_res;
  logic          cq_valid, cq_take, rq_push, rq_full;

  // Hold the slot count register.
  always_ff @(posedge clk) begin
    if (!rst_n) slots_r <= twt_pkg::SLOTS_RESET;
    else if (cfg_we) slots_r <= cfg_wheel_slots;
  end

  assign in_cmd = '{kind: in_kind, timer_id: in_timer_id,
                    loop_mode: in_loop_mode, duration: in_duration};

  twt_front u_front (
    .clk, .rst_n, .in_push, .in_full, .in_cmd,
    .cq_valid, .cq_take, .cq_cmd
  );

  twt_back #(.MAX_TIMERS(MAX_TIMERS), .SLOT_BITS(SLOT_BITS)) u_back (
    .clk, .rst_n, .slots_cfg(slots_r), .cq_valid, .cq_take, .cq_cmd,
    .rq_push, .rq_full, .rq_res
  );

  twt_outq u_outq (
    .clk, .rst_n, .rq_push, .rq_full, .rq_res, .out_empty, .out_pop, .out_res
  );

  assign out_status    = out_res.status;
  assign out_result_id = out_res.result_id;
  assign out_last      = out_res.last;

endmodule

FILE: src/twt_checker.sv
// Port-level checker for the timer table, bound to the top level.
`include "assert_macros.svh"
module twt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_empty,
  input logic        out_pop,
  input logic [2:0]  out_status,
  input logic [31:0] out_result_id,
  input logic        out_last
);
  `CHK_IMPLY(a_status_range, clk, rst_n, !out_empty,
             out_status <= twt_pkg::ST_NONE, "bad status")
  `CHK_IMPLY(a_none_last, clk, rst_n, !out_empty && out_status == twt_pkg::ST_NONE,
             out_last && out_result_id == 32'd0, "none not last")
  `CHK_IMPLY(a_nonexp_last, clk, rst_n, !out_empty && out_status != twt_pkg::ST_EXPIRED,
             out_last, "single result not last")
  `CHK_NEXT(a_hold, clk, rst_n, !out_empty && !out_pop,
            !out_empty && $stable(out_result_id), "result dropped")
endmodule

bind timing_wheel_timer_table twt_checker u_chk (.*);

FILE: test/timing_wheel_timer_table_tb.sv
// Self-checking testbench of the timing wheel timer table.
module timing_wheel_timer_table_tb;

  localparam int NUM_TIMERS = 16;
  localparam int SLOT_W = 12;
  localparam int CYCLE_LIMIT = 400000;
  localparam int IDLE_WAIT = 80;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [12:0] cfg_wheel_slots;
  logic        in_push;
  logic        in_full;
  logic [1:0]  in_kind;
  logic [31:0] in_timer_id;
  logic        in_loop_mode;
  logic [31:0] in_duration;
  logic        out_empty;
  logic        out_pop;
  logic [2:0]  out_status;
  logic [31:0] out_result_id;
  logic        out_last;

  timing_wheel_timer_table uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_wheel_slots(cfg_wheel_slots),
    .in_push(in_push), .in_full(in_full), .in_kind(in_kind),
    .in_timer_id(in_timer_id), .in_loop_mode(in_loop_mode), .in_duration(in_duration),
    .out_empty(out_empty), .out_pop(out_pop), .out_status(out_status),
    .out_result_id(out_result_id), .out_last(out_last)
  );

  // Shadow state of the wheel and its timers
  logic [12:0]       slots_reg;
  logic [SLOT_W-1:0] wheel_ptr;
  logic              tmr_valid [NUM_TIMERS];
  logic [31:0]       tmr_id [NUM_TIMERS];
  logic              tmr_loop [NUM_TIMERS];
  logic [SLOT_W-1:0] tmr_slot [NUM_TIMERS];
  logic [31:0]       tmr_reload [NUM_TIMERS];
  logic [31:0]       tmr_left [NUM_TIMERS];

  twt_pkg::res_t expected_results [$];
  int   fail_count;
  int   cycle_count;
  int   results_seen;
  int   expiries_seen;
  int   beats_sent;

  typedef struct {
    logic [1:0]  kind;
    logic [31:0] id;
    logic        loop_mode;
    logic [31:0] duration;
    bit          typed;
    logic [2:0]  status;
  } stim_row_t;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("timing_wheel_timer_table: mismatch");
        $finish;
      end
    end
  end

  function automatic logic [31:0] live_slots();
    logic [31:0] s;
    s = {19'd0, slots_reg};
    if (s == 0) s = 1;
    if (s > (32'd1 << SLOT_W)) s = 32'd1 << SLOT_W;
    return s;
  endfunction

  function automatic int lookup_timer(logic [31:0] id);
    for (int i = 0; i < NUM_TIMERS; i++)
      if (tmr_valid[i] && tmr_id[i] == id) return i;
    return -1;
  endfunction

  function automatic twt_pkg::res_t make_res(logic [2:0] st, logic [31:0] id, logic lst);
    twt_pkg::res_t r;
    r.status = st;
    r.result_id = id;
    r.last = lst;
    return r;
  endfunction

  // Advance the shadow wheel by one beat and queue the results it causes
  task automatic predict_wheel(logic [1:0] kind, logic [31:0] id, logic lp,
                               logic [31:0] dur);
    logic [31:0] s;
    logic [31:0] p;
    int ix;
    int n;
    s = live_slots();
    ix = -1;
    n = 0;
    if (kind == twt_pkg::KIND_REG) begin
      if (id == 0) expected_results.push_back(make_res(twt_pkg::ST_INVALID, id, 1'b1));
      else if (lookup_timer(id) >= 0)
        expected_results.push_back(make_res(twt_pkg::ST_DUPLICATE, id, 1'b1));
      else begin
        for (int i = NUM_TIMERS - 1; i >= 0; i--)
          if (!tmr_valid[i]) ix = i;
        if (ix < 0) expected_results.push_back(make_res(twt_pkg::ST_FULL, id, 1'b1));
        else begin
          tmr_valid[ix] = 1'b1;
          tmr_id[ix] = id;
          tmr_loop[ix] = lp;
          tmr_slot[ix] = SLOT_W'(((dur % s) + {20'd0, wheel_ptr}) % s);
          tmr_reload[ix] = dur / s;
          tmr_left[ix] = dur / s;
          expected_results.push_back(make_res(twt_pkg::ST_OK, id, 1'b1));
        end
      end
    end else if (kind == twt_pkg::KIND_UNREG) begin
      if (id == 0) expected_results.push_back(make_res(twt_pkg::ST_INVALID, id, 1'b1));
      else begin
        ix = lookup_timer(id);
        if (ix < 0) expected_results.push_back(make_res(twt_pkg::ST_NOT_FOUND, id, 1'b1));
        else begin
          tmr_valid[ix] = 1'b0;
          expected_results.push_back(make_res(twt_pkg::ST_OK, id, 1'b1));
        end
      end
    end else if (kind == twt_pkg::KIND_TICK) begin
      p = {20'd0, wheel_ptr} + 1;
      if (p >= s) p = 0;
      wheel_ptr = SLOT_W'(p);
      for (int i = 0; i < NUM_TIMERS; i++) begin
        if (tmr_valid[i] && tmr_slot[i] == wheel_ptr) begin
          if (tmr_left[i] == 0) begin
            expected_results.push_back(make_res(twt_pkg::ST_EXPIRED, tmr_id[i], 1'b0));
            n++;
            if (tmr_loop[i]) tmr_left[i] = tmr_reload[i];
            else tmr_valid[i] = 1'b0;
          end else tmr_left[i] = tmr_left[i] - 1;
        end
      end
      if (n == 0) expected_results.push_back(make_res(twt_pkg::ST_NONE, 32'd0, 1'b1));
      else expected_results[$].last = 1'b1;
    end
  endtask

  // Sender: bursts of beats with random gaps between them
  int burst_left;

  task automatic send_beat(logic [1:0] kind, logic [31:0] id, logic lp,
                           logic [31:0] dur);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    in_push <= 1'b1;
    in_kind <= kind;
    in_timer_id <= id;
    in_loop_mode <= lp;
    in_duration <= dur;
    do @(posedge clk); while (in_full);
    predict_wheel(kind, id, lp, dur);
    beats_sent++;
    burst_left--;
  endtask

  task automatic drain_results();
    in_push <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (IDLE_WAIT) @(posedge clk);
  endtask

  task automatic write_slots(logic [12:0] value);
    cfg_we <= 1'b1;
    cfg_wheel_slots <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    slots_reg = value;
  endtask

  // Receiver: stall pattern of its own, with stretches of steady popping
  initial begin
    int phase;
    out_pop = 1'b0;
    phase = 0;
    forever begin
      @(posedge clk);
      phase++;
      if ((phase / 64) % 3 == 0) out_pop <= 1'b1;
      else out_pop <= ($urandom_range(0, 3) != 0);
    end
  end

  // Compare each popped result against the oldest expectation
  always @(posedge clk) begin
    twt_pkg::res_t want;
    if (rst_n && out_pop && !out_empty) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("result with nothing expected: status %0d id %0h", out_status,
               out_result_id);
        fail_count++;
      end else begin
        want = expected_results.pop_front();
        if (want.status == twt_pkg::ST_EXPIRED) expiries_seen++;
        if (out_status !== want.status) begin
          $error("status: expected %0d actual %0d", want.status, out_status);
          fail_count++;
        end
        if (out_result_id !== want.result_id) begin
          $error("result_id: expected %0h actual %0h", want.result_id, out_result_id);
          fail_count++;
        end
        if (out_last !== want.last) begin
          $error("last: expected %0d actual %0d", want.last, out_last);
          fail_count++;
        end
      end
    end
  end

  stim_row_t directed [14] = '{
    '{twt_pkg::KIND_TICK,  32'd0,         1'b0, 32'd0,         1'b1, twt_pkg::ST_NONE},
    '{twt_pkg::KIND_REG,   32'd0,         1'b0, 32'd5,         1'b1, twt_pkg::ST_INVALID},
    '{twt_pkg::KIND_UNREG, 32'd0,         1'b0, 32'd0,         1'b1, twt_pkg::ST_INVALID},
    '{twt_pkg::KIND_UNREG, 32'd77,        1'b0, 32'd0,         1'b1, twt_pkg::ST_NOT_FOUND},
    '{twt_pkg::KIND_REG,   32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b1, twt_pkg::ST_OK},
    '{twt_pkg::KIND_REG,   32'hFFFF_FFFF, 1'b0, 32'd1,         1'b1, twt_pkg::ST_DUPLICATE},
    '{twt_pkg::KIND_REG,   32'd1,         1'b0, 32'd1,         1'b1, twt_pkg::ST_OK},
    '{twt_pkg::KIND_REG,   32'd2,         1'b1, 32'd0,         1'b0, twt_pkg::ST_OK},
    '{twt_pkg::KIND_REG,   32'd3,         1'b0, 32'd1,         1'b0, twt_pkg::ST_OK},
    '{twt_pkg::KIND_BAD,   32'd9,         1'b1, 32'd9,         1'b0, twt_pkg::ST_OK},
    '{twt_pkg::KIND_TICK,  32'd0,         1'b0, 32'd0,         1'b0, twt_pkg::ST_OK},
    '{twt_pkg::KIND_TICK,  32'd0,         1'b0, 32'd0,         1'b0, twt_pkg::ST_OK},
    '{twt_pkg::KIND_UNREG, 32'hFFFF_FFFF, 1'b0, 32'd0,         1'b1, twt_pkg::ST_OK},
    '{twt_pkg::KIND_UNREG, 32'd2,         1'b0, 32'd0,         1'b0, twt_pkg::ST_OK}
  };

  logic [31:0] id_pool [8];

  task automatic random_phase(int beats, int fill_table);
    logic [1:0] kind;
    logic [31:0] id;
    logic [31:0] dur;
    int pick;
    for (int i = 0; i < fill_table; i++)
      send_beat(twt_pkg::KIND_REG, 32'd1000 + i, 1'($urandom),
                32'($urandom_range(0, 3000)));
    if (fill_table > 0) send_beat(twt_pkg::KIND_REG, 32'd5000, 1'b0, 32'd1);
    for (int n = 0; n < beats; n++) begin
      pick = $urandom_range(0, 19);
      kind = pick < 9 ? twt_pkg::KIND_TICK : pick < 15 ? twt_pkg::KIND_REG :
             pick < 19 ? twt_pkg::KIND_UNREG : twt_pkg::KIND_BAD;
      id = ($urandom_range(0, 9) == 0) ? 32'($urandom) : id_pool[$urandom_range(0, 7)];
      case ($urandom_range(0, 4))
        0: dur = $urandom;
        1: dur = 32'($urandom_range(0, 3));
        default: dur = 32'($urandom_range(0, 3 * live_slots()));
      endcase
      send_beat(kind, id, 1'($urandom), dur);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wheel_slots = twt_pkg::SLOTS_RESET;
    in_push = 1'b0;
    in_kind = twt_pkg::KIND_TICK;
    in_timer_id = '0;
    in_loop_mode = 1'b0;
    in_duration = '0;
    fail_count = 0;
    results_seen = 0;
    expiries_seen = 0;
    beats_sent = 0;
    burst_left = 0;
    slots_reg = twt_pkg::SLOTS_RESET;
    wheel_ptr = '0;
    for (int i = 0; i < NUM_TIMERS; i++) tmr_valid[i] = 1'b0;
    id_pool = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'hFFFF_FFFF, 32'hAAAA_5555,
                32'h5555_AAAA};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows at reset slot count, then at two slots
    foreach (directed[r]) begin
      if (r == 9) begin
        drain_results();
        write_slots(13'd2);
      end
      send_beat(directed[r].kind, directed[r].id, directed[r].loop_mode,
                directed[r].duration);
      if (directed[r].typed && expected_results[$].status !== directed[r].status) begin
        $error("status: expected %0d actual %0d", directed[r].status,
               expected_results[$].status);
        fail_count++;
      end
    end

    // Random phases over several slot counts, extremes included
    drain_results();
    write_slots(13'd0);
    random_phase(40, 16);
    drain_results();
    write_slots(13'd3);
    random_phase(90, 0);
    drain_results();
    write_slots(13'h1FFF);
    random_phase(30, 0);
    drain_results();
    write_slots(13'd4096);
    random_phase(30, 0);
    drain_results();
    write_slots(13'd5);
    random_phase(110, 0);
    drain_results();

    $display("covered %0d beats, %0d results checked, %0d expiries", beats_sent,
             results_seen, expiries_seen);
    $display("slot counts 0, 1, 2, 3, 5, 1000, 4096 and above, full table included");
    if (fail_count == 0) $display("timing_wheel_timer_table: match");
    else $display("timing_wheel_timer_table: mismatch");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+src
src/twt_pkg.sv
src/twt_front.sv
src/twt_back.sv
src/twt_outq.sv
src/timing_wheel_timer_table.sv
src/twt_checker.sv
test/timing_wheel_timer_table_tb.sv
